@@ sv/tdr_pkg.sv @@
// Package for the TFTP download receiver: queue item type, queue depth, command,
// action, opcode and register index codes, and configuration reset defaults. No dependencies.
package tdr_pkg;

  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [15:0] OPC_DATA   = 16'd3;
  localparam logic [15:0] HDR_BYTES  = 16'd4;
  localparam logic [15:0] BLOCK_WRAP = 16'hffff;

  localparam logic [7:0] CFG_SERVER_IP     = 8'd0;
  localparam logic [7:0] CFG_SERVER_PORT   = 8'd1;
  localparam logic [7:0] CFG_FLASH_BASE    = 8'd2;
  localparam logic [7:0] CFG_TIMEOUT_LIMIT = 8'd3;

  localparam logic [31:0] RST_SERVER_IP     = 32'd0;
  localparam logic [15:0] RST_SERVER_PORT   = 16'd69;
  localparam logic [31:0] RST_FLASH_BASE    = 32'd0;
  localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd100;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_REQUEST = 3'd1,
    ACT_REFUSED = 3'd2,
    ACT_ACK     = 3'd3,
    ACT_WRITE   = 3'd4,
    ACT_DROPPED = 3'd5,
    ACT_TIMEOUT = 3'd6
  } action_t;

  // A classified request as it travels from the front end to the executor.
  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_data;
    logic        hdr_short;
    logic        blk_is_one;
    logic        is_last;
    logic [15:0] blk;
    logic [15:0] len;
    logic [31:0] src_ip;
    logic [15:0] src_port;
  } item_t;

endpackage

@@ sv/tdr_front.sv @@
// Front end of the TFTP download receiver: accepts requests, clamps the
// length and classifies the packet header into one registered item.
// Depends on tdr_pkg.
module tdr_front #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_pkt_opcode,
  input  logic [15:0]        in_pkt_block,
  input  logic [15:0]        in_pkt_length,
  input  logic [31:0]        in_src_ip,
  input  logic [15:0]        in_src_port,
  output logic               push_valid,
  input  logic               push_ready,
  output tdr_pkg::item_t     push_item
);
  import tdr_pkg::*;

  localparam logic [15:0] FULL_BYTES = 16'(BLOCK_BYTES + 4);

  logic  stage_valid_r;
  logic  stage_valid_nxt;
  item_t stage_r;
  item_t stage_nxt;
  logic  [15:0] len_clamped;

  assign in_ready   = !stage_valid_r || push_ready;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_r;

  always_comb begin
    len_clamped          = (in_pkt_length > FULL_BYTES) ? FULL_BYTES : in_pkt_length;
    stage_nxt.cmd        = in_command;
    stage_nxt.is_data    = (in_pkt_opcode == OPC_DATA);
    stage_nxt.hdr_short  = (len_clamped < HDR_BYTES);
    stage_nxt.blk_is_one = (in_pkt_block == 16'd1);
    stage_nxt.is_last    = (len_clamped < FULL_BYTES);
    stage_nxt.blk        = in_pkt_block;
    stage_nxt.len        = len_clamped;
    stage_nxt.src_ip     = in_src_ip;
    stage_nxt.src_port   = in_src_port;
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_valid && in_ready) begin
      stage_valid_nxt = 1'b1;
    end else if (push_ready) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

@@ sv/tdr_queue.sv @@
// Short queue between the front end and the executor so that each side
// can stall on its own. Depends on tdr_pkg.
module tdr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tdr_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tdr_pkg::item_t pop_item
);
  import tdr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != DEPTH_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entries[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ sv/tdr_back.sv @@
// Executor of the TFTP download receiver: holds the configuration and the
// session state, decides each queued request and registers the result.
// Depends on tdr_pkg.
module tdr_back #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_write,
  input  logic [7:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  tdr_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_action,
  output logic [15:0]    out_ack_block,
  output logic [31:0]    out_dest_ip,
  output logic [15:0]    out_dest_port,
  output logic [31:0]    out_write_addr,
  output logic [7:0]     out_write_words,
  output logic           out_session_done
);
  import tdr_pkg::*;

  localparam int unsigned WORDS_W = $clog2((BLOCK_BYTES + 3) / 4 + 1);

  logic [31:0] server_ip_r;
  logic [15:0] server_port_r;
  logic [31:0] flash_base_r;
  logic [15:0] timeout_limit_r;

  logic        active_r, active_nxt;
  logic [15:0] last_block_r, last_block_nxt;
  logic [31:0] peer_ip_r, peer_ip_nxt;
  logic [15:0] peer_port_r, peer_port_nxt;
  logic [31:0] waddr_r, waddr_nxt;
  logic [15:0] idle_r, idle_nxt;

  logic        out_valid_r, out_valid_nxt;
  action_t     act_r, act_nxt;
  logic [15:0] ack_r, ack_nxt;
  logic [31:0] dip_r, dip_nxt;
  logic [15:0] dport_r, dport_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [7:0]  owords_r, owords_nxt;
  logic        done_r, done_nxt;

  logic               fire;
  logic [15:0]        next_blk;
  logic [15:0]        len_m1;
  logic [WORDS_W-1:0] words;
  logic               latch_peer;
  logic [31:0]        eff_ip;
  logic [15:0]        eff_port;

  assign pop_ready        = !out_valid_r || out_ready;
  assign fire             = pop_valid && pop_ready;
  assign out_valid        = out_valid_r;
  assign out_action       = act_r;
  assign out_ack_block    = ack_r;
  assign out_dest_ip      = dip_r;
  assign out_dest_port    = dport_r;
  assign out_write_addr   = oaddr_r;
  assign out_write_words  = owords_r;
  assign out_session_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_ip_r     <= RST_SERVER_IP;
      server_port_r   <= RST_SERVER_PORT;
      flash_base_r    <= RST_FLASH_BASE;
      timeout_limit_r <= RST_TIMEOUT_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SERVER_IP:     server_ip_r     <= cfg_data;
        CFG_SERVER_PORT:   server_port_r   <= cfg_data[15:0];
        CFG_FLASH_BASE:    flash_base_r    <= cfg_data;
        CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Words are ceil((len - 4) / 4), which for len of at least four is (len - 1) / 4.
  assign next_blk   = last_block_r + 16'd1;
  assign len_m1     = pop_item.len - 16'd1;
  assign words      = len_m1[WORDS_W+1:2];
  assign latch_peer = pop_item.blk_is_one && (next_blk == 16'd1);
  assign eff_ip     = latch_peer ? pop_item.src_ip : peer_ip_r;
  assign eff_port   = latch_peer ? pop_item.src_port : peer_port_r;

  always_comb begin
    active_nxt     = active_r;
    last_block_nxt = last_block_r;
    peer_ip_nxt    = peer_ip_r;
    peer_port_nxt  = peer_port_r;
    waddr_nxt      = waddr_r;
    idle_nxt       = idle_r;
    act_nxt        = ACT_NONE;
    ack_nxt        = '0;
    dip_nxt        = '0;
    dport_nxt      = '0;
    oaddr_nxt      = '0;
    owords_nxt     = '0;
    done_nxt       = 1'b0;

    unique case (pop_item.cmd)
      CMD_START: begin
        if (active_r) begin
          act_nxt = ACT_REFUSED;
        end else begin
          active_nxt     = 1'b1;
          last_block_nxt = '0;
          peer_ip_nxt    = server_ip_r;
          peer_port_nxt  = server_port_r;
          waddr_nxt      = flash_base_r;
          idle_nxt       = '0;
          act_nxt        = ACT_REQUEST;
          dip_nxt        = server_ip_r;
          dport_nxt      = server_port_r;
        end
      end
      CMD_TICK: begin
        if (active_r) begin
          if (idle_r > timeout_limit_r) begin
            active_nxt = 1'b0;
            act_nxt    = ACT_TIMEOUT;
          end
          idle_nxt = idle_r + 16'd1;
        end
      end
      CMD_PACKET: begin
        if (active_r) begin
          idle_nxt = '0;
          if (pop_item.is_data) begin
            priority if (pop_item.hdr_short) begin
              act_nxt = ACT_DROPPED;
            end else if (!pop_item.blk_is_one &&
                         (peer_ip_r != pop_item.src_ip ||
                          peer_port_r != pop_item.src_port)) begin
              act_nxt = ACT_DROPPED;
            end else begin
              peer_ip_nxt   = eff_ip;
              peer_port_nxt = eff_port;
              priority if (next_blk > pop_item.blk ||
                           (next_blk == '0 && pop_item.blk == BLOCK_WRAP)) begin
                act_nxt   = ACT_ACK;
                ack_nxt   = pop_item.blk;
                dip_nxt   = eff_ip;
                dport_nxt = eff_port;
              end else if (next_blk == pop_item.blk) begin
                act_nxt        = ACT_WRITE;
                ack_nxt        = next_blk;
                dip_nxt        = eff_ip;
                dport_nxt      = eff_port;
                oaddr_nxt      = waddr_r;
                owords_nxt     = 8'(words);
                waddr_nxt      = waddr_r + (32'(words) << 2);
                last_block_nxt = next_blk;
                if (pop_item.is_last) begin
                  done_nxt   = 1'b1;
                  active_nxt = 1'b0;
                end
              end else begin
                act_nxt = ACT_DROPPED;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      active_r     <= 1'b0;
      last_block_r <= '0;
      peer_ip_r    <= '0;
      peer_port_r  <= '0;
      waddr_r      <= '0;
      idle_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        active_r     <= active_nxt;
        last_block_r <= last_block_nxt;
        peer_ip_r    <= peer_ip_nxt;
        peer_port_r  <= peer_port_nxt;
        waddr_r      <= waddr_nxt;
        idle_r       <= idle_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      act_r    <= act_nxt;
      ack_r    <= ack_nxt;
      dip_r    <= dip_nxt;
      dport_r  <= dport_nxt;
      oaddr_r  <= oaddr_nxt;
      owords_r <= owords_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

@@ sv/tftp_download_receiver_core.sv @@
// TFTP download receiver: one result per request, one request per cycle
// sustained while out_ready stays high. A request is registered in the front
// end when accepted, is then written into the queue and is then decided into
// the result register; back-pressure can hold it at either step.
// Synchronous active-low reset clears the session, the queue and the
// output register, and loads the configuration defaults.
module tftp_download_receiver_core #(
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_pkt_opcode,
  input  logic [15:0] in_pkt_block,
  input  logic [15:0] in_pkt_length,
  input  logic [31:0] in_src_ip,
  input  logic [15:0] in_src_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [15:0] out_ack_block,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_dest_port,
  output logic [31:0] out_write_addr,
  output logic [7:0]  out_write_words,
  output logic        out_session_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tdr_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  assign cfg_ready = 1'b1;

  tdr_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_pkt_opcode (in_pkt_opcode),
    .in_pkt_block  (in_pkt_block),
    .in_pkt_length (in_pkt_length),
    .in_src_ip     (in_src_ip),
    .in_src_port   (in_src_port),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  tdr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  tdr_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_ack_block    (out_ack_block),
    .out_dest_ip      (out_dest_ip),
    .out_dest_port    (out_dest_port),
    .out_write_addr   (out_write_addr),
    .out_write_words  (out_write_words),
    .out_session_done (out_session_done)
  );

endmodule
